>>> hw/rtl/dag_longest_path_parent_defines.svh
// Assertion macros for the longest-path parent RTL.
`ifndef DAG_LONGEST_PATH_PARENT_DEFINES_SVH
`define DAG_LONGEST_PATH_PARENT_DEFINES_SVH
`ifndef ASSERT_OFF
`define DLP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DLP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLP_ASSERT(label, prop, msg)
`define DLP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> hw/rtl/dlp_pkg.sv
// Types and constants shared by the longest-path parent controller and datapath.
package dlp_pkg;

	localparam int NODE_W = 11;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_INC,
		OP_QUERY,
		OP_QOUT,
		OP_SWEEP_ALL,
		OP_SWEEP_FIND,
		OP_SWEEP_DEG,
		OP_ROOT,
		OP_FIN,
		OP_POP,
		OP_NOW,
		OP_EDGE0,
		OP_ERD,
		OP_ECHK,
		OP_ENEXT,
		OP_UPD
	} dlp_op_t;

	typedef struct packed {
		dlp_op_t op;
		logic    sweep_init;
	} dlp_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic root_found;
		logic queue_empty;
		logic edge_more;
		logic edge_match;
	} dlp_sts_t;

endpackage

>>> hw/rtl/dlp_dp.sv
// Datapath of the longest-path parent block: edge, node and queue memories.
module dlp_dp #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dlp_pkg::dlp_cmd_t         cmd,
	output dlp_pkg::dlp_sts_t         sts,
	input  logic                      cfg_we,
	input  logic [dlp_pkg::NODE_W-1:0] cfg_wdata,
	input  logic [dlp_pkg::NODE_W-1:0] src_node,
	input  logic [dlp_pkg::NODE_W-1:0] dst_node,
	input  logic [dlp_pkg::NODE_W-1:0] query_node,
	output logic [dlp_pkg::NODE_W-1:0] parent_node,
	output logic                      reached
);
	import dlp_pkg::*;

	localparam int NIW = $clog2(MAX_NODES);
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW = $clog2(MAX_EDGES + 1);
	localparam int IDW = ETW;
	localparam int DW  = CW;
	localparam logic [CW-1:0]  NODES_C = CW'(MAX_NODES);
	localparam logic [ETW-1:0] EDGES_C = ETW'(MAX_EDGES);

	logic [NODE_W-1:0] node_count_q;
	logic [ETW-1:0]    edge_total_q;
	logic [CW-1:0]     sweep_q;
	logic              chk_v_s1;
	logic [NIW-1:0]    chk_idx_s1;
	logic              root_found_q;
	logic [NODE_W-1:0] root_q;
	logic [CW-1:0]     head_q;
	logic [CW-1:0]     tail_q;
	logic [NODE_W-1:0] now_q;
	logic [DW-1:0]     dist_now_q;
	logic [ETW-1:0]    e_q;
	logic [NODE_W-1:0] nxt_q;
	logic              stored_q;
	logic              qok_q;
	logic [NODE_W-1:0] parent_q;
	logic              reached_q;

	logic [NODE_W-1:0] esrc_mem [MAX_EDGES];
	logic [NODE_W-1:0] edst_mem [MAX_EDGES];
	logic [IDW-1:0]    deg_mem  [MAX_NODES];
	logic [DW-1:0]     dist_mem [MAX_NODES];
	logic [NODE_W-1:0] par_mem  [MAX_NODES];
	logic              rch_mem  [MAX_NODES];
	logic [NODE_W-1:0] que_mem  [MAX_NODES];

	logic [NODE_W-1:0] src_rd, dst_rd, par_rd, que_rd;
	logic [IDW-1:0]    deg_rd;
	logic [DW-1:0]     dist_rd;
	logic              rch_rd;

	logic              src_ok, dst_ok, q_ok, store_edge;
	logic [NIW-1:0]    dst_idx, q_idx, rd_dst_idx, que_idx, nxt_idx, root_idx, sw_idx;
	logic              sw_op, sw_go;
	logic [31:0]       nc32, n_eff;
	logic [IDW-1:0]    deg_dec;
	logic [DW-1:0]     new_d;
	logic              take, push;
	logic [NIW-1:0]    deg_raddr, dist_raddr, rch_raddr;

	assign src_ok     = (src_node != '0) && (32'(src_node) <= 32'(MAX_NODES));
	assign dst_ok     = (dst_node != '0) && (32'(dst_node) <= 32'(MAX_NODES));
	assign q_ok       = (query_node != '0) && (32'(query_node) <= 32'(MAX_NODES));
	assign store_edge = src_ok && dst_ok && (edge_total_q < EDGES_C);

	assign dst_idx    = NIW'(dst_node - NODE_W'(1));
	assign q_idx      = NIW'(query_node - NODE_W'(1));
	assign rd_dst_idx = NIW'(dst_rd - NODE_W'(1));
	assign que_idx    = NIW'(que_rd - NODE_W'(1));
	assign nxt_idx    = NIW'(nxt_q - NODE_W'(1));
	assign root_idx   = NIW'(root_q - NODE_W'(1));
	assign sw_idx     = sweep_q[NIW-1:0];

	assign sw_op = (cmd.op == OP_SWEEP_ALL) || (cmd.op == OP_SWEEP_FIND) ||
		(cmd.op == OP_SWEEP_DEG);
	assign sw_go = sw_op && (sweep_q < NODES_C);

	assign nc32  = 32'(node_count_q);
	assign n_eff = (nc32 == 32'd0) ? 32'd1 :
		((nc32 > 32'(MAX_NODES)) ? 32'(MAX_NODES) : nc32);

	assign deg_dec = (deg_rd != '0) ? (deg_rd - IDW'(1)) : '0;
	assign new_d   = dist_now_q + DW'(1);
	assign take    = !rch_rd || (dist_rd < new_d);
	assign push    = (deg_dec == '0) && (tail_q < NODES_C);

	always_comb begin
		case (cmd.op)
			OP_LOAD: deg_raddr = dst_idx;
			OP_ECHK: deg_raddr = rd_dst_idx;
			default: deg_raddr = sw_idx;
		endcase
		case (cmd.op)
			OP_NOW:  dist_raddr = que_idx;
			default: dist_raddr = rd_dst_idx;
		endcase
		case (cmd.op)
			OP_QUERY: rch_raddr = q_idx;
			default:  rch_raddr = rd_dst_idx;
		endcase
	end

	assign sts.sweep_done  = (sweep_q == NODES_C) && !chk_v_s1;
	assign sts.root_found  = root_found_q;
	assign sts.queue_empty = (head_q == tail_q);
	assign sts.edge_more   = (e_q < edge_total_q);
	assign sts.edge_match  = (src_rd == now_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_W'(1);
			edge_total_q <= '0;
			sweep_q      <= '0;
			chk_v_s1     <= 1'b0;
			root_found_q <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			e_q          <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (cmd.sweep_init) begin
				sweep_q      <= '0;
				chk_v_s1     <= 1'b0;
				root_found_q <= 1'b0;
			end else if (sw_op) begin
				chk_v_s1 <= sw_go;
				if (sw_go) begin
					sweep_q <= sweep_q + CW'(1);
				end
				if (cmd.op == OP_SWEEP_FIND && chk_v_s1 && !root_found_q &&
					deg_rd == '0 && 32'(chk_idx_s1) < n_eff) begin
					root_found_q <= 1'b1;
				end
			end
			case (cmd.op)
				OP_LOAD: begin
					if (store_edge) begin
						edge_total_q <= edge_total_q + ETW'(1);
					end
				end
				OP_FIN: edge_total_q <= '0;
				OP_ROOT: begin
					head_q <= '0;
					tail_q <= CW'(1);
				end
				OP_POP:   head_q <= head_q + CW'(1);
				OP_EDGE0: e_q <= '0;
				OP_ENEXT: e_q <= e_q + ETW'(1);
				OP_UPD: begin
					e_q <= e_q + ETW'(1);
					if (push) begin
						tail_q <= tail_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= sw_idx;
		if (cmd.op == OP_SWEEP_FIND && chk_v_s1 && !root_found_q &&
			deg_rd == '0 && 32'(chk_idx_s1) < n_eff) begin
			root_q <= NODE_W'(32'(chk_idx_s1) + 32'd1);
		end
		case (cmd.op)
			OP_LOAD: begin
				stored_q <= store_edge;
				nxt_q    <= dst_node;
			end
			OP_QUERY: qok_q <= q_ok;
			OP_QOUT: begin
				parent_q  <= (qok_q && rch_rd) ? par_rd : '0;
				reached_q <= qok_q && rch_rd;
			end
			OP_NOW:   now_q <= que_rd;
			OP_EDGE0: dist_now_q <= dist_rd;
			OP_ECHK:  nxt_q <= dst_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && store_edge) begin
			esrc_mem[edge_total_q[EW-1:0]] <= src_node;
			edst_mem[edge_total_q[EW-1:0]] <= dst_node;
		end
		src_rd <= esrc_mem[e_q[EW-1:0]];
		dst_rd <= edst_mem[e_q[EW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_INC && stored_q) begin
			deg_mem[nxt_idx] <= deg_rd + IDW'(1);
		end else if (cmd.op == OP_UPD) begin
			deg_mem[nxt_idx] <= deg_dec;
		end else if (sw_go && cmd.op != OP_SWEEP_FIND) begin
			deg_mem[sw_idx] <= '0;
		end
		deg_rd <= deg_mem[deg_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ROOT) begin
			dist_mem[root_idx] <= '0;
		end else if (cmd.op == OP_UPD && take) begin
			dist_mem[nxt_idx] <= new_d;
		end
		dist_rd <= dist_mem[dist_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ROOT) begin
			par_mem[root_idx] <= '0;
		end else if (cmd.op == OP_UPD && take) begin
			par_mem[nxt_idx] <= now_q;
		end
		par_rd <= par_mem[q_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ROOT) begin
			rch_mem[root_idx] <= 1'b1;
		end else if (cmd.op == OP_UPD && take) begin
			rch_mem[nxt_idx] <= 1'b1;
		end else if (sw_go && cmd.op != OP_SWEEP_DEG) begin
			rch_mem[sw_idx] <= 1'b0;
		end
		rch_rd <= rch_mem[rch_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ROOT) begin
			que_mem[0] <= root_q;
		end else if (cmd.op == OP_UPD && push) begin
			que_mem[tail_q[NIW-1:0]] <= nxt_q;
		end
		que_rd <= que_mem[head_q[NIW-1:0]];
	end

	assign parent_node = parent_q;
	assign reached     = reached_q;

endmodule

>>> hw/rtl/dlp_ctrl.sv
// Controller state machine of the longest-path parent block.
`include "dag_longest_path_parent_defines.svh"
module dlp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic              last_edge,
	output logic              out_valid,
	input  logic              out_ready,
	output dlp_pkg::dlp_cmd_t cmd,
	input  dlp_pkg::dlp_sts_t sts
);
	import dlp_pkg::*;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_QOUT,
		S_INC,
		S_FIND,
		S_POP,
		S_NOW,
		S_EDGE0,
		S_ERD,
		S_ECHK,
		S_UPD,
		S_DEG
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   last_q;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op         = OP_IDLE;
		cmd.sweep_init = 1'b0;
		state_d        = state_q;
		case (state_q)
			S_CLR: begin
				if (sts.sweep_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_SWEEP_ALL;
				end
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (req_type) begin
						cmd.op  = OP_QUERY;
						state_d = S_QOUT;
					end else begin
						cmd.op  = OP_LOAD;
						state_d = S_INC;
					end
				end
			end
			S_QOUT: begin
				cmd.op  = OP_QOUT;
				state_d = S_IDLE;
			end
			S_INC: begin
				cmd.op = OP_INC;
				if (last_q) begin
					cmd.sweep_init = 1'b1;
					state_d        = S_FIND;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FIND: begin
				if (!sts.sweep_done) begin
					cmd.op = OP_SWEEP_FIND;
				end else if (sts.root_found) begin
					cmd.op  = OP_ROOT;
					state_d = S_POP;
				end else begin
					cmd.op         = OP_FIN;
					cmd.sweep_init = 1'b1;
					state_d        = S_DEG;
				end
			end
			S_POP: begin
				if (sts.queue_empty) begin
					cmd.op         = OP_FIN;
					cmd.sweep_init = 1'b1;
					state_d        = S_DEG;
				end else begin
					cmd.op  = OP_POP;
					state_d = S_NOW;
				end
			end
			S_NOW: begin
				cmd.op  = OP_NOW;
				state_d = S_EDGE0;
			end
			S_EDGE0: begin
				cmd.op  = OP_EDGE0;
				state_d = S_ERD;
			end
			S_ERD: begin
				if (sts.edge_more) begin
					cmd.op  = OP_ERD;
					state_d = S_ECHK;
				end else begin
					state_d = S_POP;
				end
			end
			S_ECHK: begin
				if (sts.edge_match) begin
					cmd.op  = OP_ECHK;
					state_d = S_UPD;
				end else begin
					cmd.op  = OP_ENEXT;
					state_d = S_ERD;
				end
			end
			S_UPD: begin
				cmd.op  = OP_UPD;
				state_d = S_ERD;
			end
			S_DEG: begin
				if (sts.sweep_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_SWEEP_DEG;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid && in_ready && !req_type) begin
				last_q <= last_edge;
			end
			if (state_q == S_QOUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DLP_ASSERT(a_ready_room, in_ready |-> (!out_valid_q || out_ready), "input taken with output slot full")
	`DLP_ASSERT(a_query_then_out, (in_valid && in_ready && req_type) |=> (state_q == S_QOUT), "query beat not followed by result capture")
	`DLP_ASSERT_ALWAYS(a_qout_slot_free, (state_q == S_QOUT) |-> !out_valid_q, "result captured over a waiting result")
	`DLP_ASSERT(a_out_from_qout, $rose(out_valid_q) |-> $past(state_q == S_QOUT), "result raised without a query")

endmodule

>>> hw/rtl/dag_longest_path_parent.sv
// Top level of the longest-path parent block: controller plus datapath.
// Usage: the input channel (in_valid/in_ready) carries one beat per item. A beat
// with req_type 0 loads the edge src_node -> dst_node when both nodes lie in
// 1..MAX_NODES and the edge memory has room. A load beat with last_edge set
// then runs the traversal: a sweep finds the root, the Kahn queue pops each
// queued node and scans every stored edge (with an extra update step when the
// edge leaves the popped node), and a final sweep clears in-degrees.
// A beat with req_type 1 asks for the parent of query_node; its result beat
// (parent_node, reached) is captured in the S_QOUT state and then offered on
// out_valid. A new query is taken only after the previous result has been
// captured, while the receiver keeps out_ready high.
// When the receiver stalls, the result waits in the output register and new
// input is held off until it is taken.
// After reset a clearing sweep runs with in_ready low; node_count resets to 1
// and may be written through cfg_we at any idle time.
module dag_longest_path_parent #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [dlp_pkg::NODE_W-1:0] src_node,
	input  logic [dlp_pkg::NODE_W-1:0] dst_node,
	input  logic                       last_edge,
	input  logic [dlp_pkg::NODE_W-1:0] query_node,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dlp_pkg::NODE_W-1:0] parent_node,
	output logic                       reached,
	input  logic                       cfg_we,
	input  logic [dlp_pkg::NODE_W-1:0] cfg_wdata
);
	import dlp_pkg::*;

	dlp_cmd_t cmd;
	dlp_sts_t sts;

	dlp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.last_edge (last_edge),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dlp_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.src_node    (src_node),
		.dst_node    (dst_node),
		.query_node  (query_node),
		.parent_node (parent_node),
		.reached     (reached)
	);

endmodule
